// File: rtl/mwg_pkg.sv
// Shared types and constants of the morphing waveshape generator.
// No dependencies; every other rtl file but mwg_checker imports this package.
package mwg_pkg;

   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // register indexes of the configuration port
   localparam logic [1:0] CSR_SHAPE  = 2'd0;
   localparam logic [1:0] CSR_JITTER = 2'd1;

   // one period of the morph position, 3.0 in Q.24
   localparam logic [27:0] POS_WRAP = 28'd50331648;

   localparam logic [16:0] ONE_Q16  = 17'd65536;
   localparam logic [16:0] QTR_Q16  = 17'd16384;
   localparam logic [16:0] HALF_Q16 = 17'd32768;
   localparam logic [16:0] TQTR_Q16 = 17'd49152;

   localparam logic signed [16:0] FULL_POS = 17'sd32768;
   localparam logic signed [16:0] FULL_NEG = -17'sd32768;

   // per-region loudness: offset and slope, Q0.16
   localparam logic [16:0] AMP0_BASE  = 17'd26214;
   localparam logic [15:0] AMP0_SLOPE = 16'd39322;
   localparam logic [15:0] AMP1_SLOPE = 16'd45875;
   localparam logic [16:0] AMP2_BASE  = 17'd19661;
   localparam logic [15:0] AMP2_SLOPE = 16'd6554;

   // one classified word: segment ramp job plus loudness
   typedef struct packed {
      logic [15:0]        num;
      logic [16:0]        den;
      logic               sh16;
      logic signed [16:0] base;
      logic               sub;
      logic               use_ramp;
      logic [16:0]        amp;
   } seg_type;

endpackage

// File: rtl/mwg_front.sv
// Front end: accepts a word, updates the jitter level, wraps the morph position,
// computes the morph value and classifies the segment. Depends on mwg_pkg.
module mwg_front
   import mwg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_phase,
   input  logic [15:0] req_noise,
   input  logic [15:0] shape_position,
   input  logic [15:0] jitter_amount,
   input  logic        q_full,
   output logic        push,
   output seg_type     push_data
);

   typedef enum logic [9:0] {
      F_IDLE  = 10'b0000000001,
      F_JIT   = 10'b0000000010,
      F_LVL   = 10'b0000000100,
      F_SUM   = 10'b0000001000,
      F_WRAP1 = 10'b0000010000,
      F_WRAP2 = 10'b0000100000,
      F_SQ    = 10'b0001000000,
      F_MORPH = 10'b0010000000,
      F_SEG   = 10'b0100000000,
      F_PUSH  = 10'b1000000000
   } fstate_type;

   fstate_type  state_ff, state_in;
   logic [15:0] phase_ff, phase_in;
   logic [15:0] noise_ff, noise_in;
   logic [15:0] r_ff, r_in;
   logic [23:0] jl_ff, jl_in;
   logic [27:0] pos_ff, pos_in;
   logic [15:0] x2_ff, x2_in;
   logic [15:0] m_ff, m_in;
   seg_type     seg_ff, seg_in;

   logic [31:0] noise_prod;
   logic [31:0] lvl_sum;
   logic [31:0] sq_prod;
   logic [33:0] morph_prod;
   logic [17:0] morph_fac;
   logic [15:0] x;

   assign x          = pos_ff[23:8];
   assign noise_prod = noise_ff * jitter_amount;
   assign lvl_sum    = ({8'd0, jl_ff} << 7) - {8'd0, jl_ff} + {8'd0, r_ff, 8'd0};
   assign sq_prod    = x * x;
   assign morph_fac  = 18'd196608 - {1'b0, x, 1'b0};
   assign morph_prod = x2_ff * morph_fac;

   // segment classification and loudness
   always_comb begin
      logic [16:0] p, q, h, e1, e2, e3, e4;
      logic [31:0] aprod;
      logic [15:0] coef;
      seg_type     s;
      p = {1'b0, phase_ff};
      q = {3'd0, m_ff[15:2]};
      h = {2'd0, m_ff[15:1]};
      s = '0;
      coef = AMP2_SLOPE;
      e1 = '0; e2 = '0; e3 = '0; e4 = '0;
      case (pos_ff[25:24])
         2'd0: begin
            coef = AMP0_SLOPE;
            e1 = q;
            e2 = ONE_Q16 - q;
            if (p < e1) begin
               s.base = '0; s.num = p[15:0]; s.den = e1; s.use_ramp = 1'b1;
            end else if (p < e2) begin
               s.base = FULL_POS; s.sub = 1'b1; s.sh16 = 1'b1;
               s.num = 16'(p - e1); s.den = e2 - e1; s.use_ramp = 1'b1;
            end else begin
               s.base = FULL_NEG; s.num = 16'(p - e2); s.den = ONE_Q16 - e2;
               s.use_ramp = 1'b1;
            end
         end
         2'd1: begin
            coef = AMP1_SLOPE;
            e1 = QTR_Q16 - q;
            e2 = QTR_Q16 + q;
            e3 = TQTR_Q16 - q;
            e4 = TQTR_Q16 + q;
            if (p < e1) begin
               s.base = '0; s.num = p[15:0]; s.den = e1; s.use_ramp = 1'b1;
            end else if (p < e2) begin
               s.base = FULL_POS;
            end else if (p < e3) begin
               s.base = FULL_POS; s.sub = 1'b1; s.sh16 = 1'b1;
               s.num = 16'(p - e2); s.den = e3 - e2; s.use_ramp = 1'b1;
            end else if (p < e4) begin
               s.base = FULL_NEG;
            end else begin
               s.base = FULL_NEG; s.num = 16'(p - e4); s.den = ONE_Q16 - e4;
               s.use_ramp = 1'b1;
            end
         end
         default: begin
            e1 = HALF_Q16 - h;
            e2 = HALF_Q16 + h;
            if (p < e1) begin
               s.base = FULL_POS;
            end else if (p < e2) begin
               s.base = FULL_POS; s.sub = 1'b1; s.sh16 = 1'b1;
               s.num = 16'(p - e1); s.den = e2 - e1; s.use_ramp = 1'b1;
            end else begin
               s.base = FULL_NEG;
            end
         end
      endcase
      // an empty segment yields its start value
      if (s.den == '0) begin
         s.use_ramp = 1'b0;
      end
      aprod = coef * m_ff;
      case (pos_ff[25:24])
         2'd0:    s.amp = AMP0_BASE + {1'b0, aprod[31:16]};
         2'd1:    s.amp = ONE_Q16 - {1'b0, aprod[31:16]};
         default: s.amp = AMP2_BASE + {1'b0, aprod[31:16]};
      endcase
      seg_in = s;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      noise_in = noise_ff;
      r_in     = r_ff;
      jl_in    = jl_ff;
      pos_in   = pos_ff;
      x2_in    = x2_ff;
      m_in     = m_ff;
      push     = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               phase_in = req_phase;
               noise_in = req_noise;
               state_in = F_JIT;
            end
         end
         F_JIT: begin
            r_in     = noise_prod[31:16];
            state_in = F_LVL;
         end
         F_LVL: begin
            jl_in    = lvl_sum[30:7];
            state_in = F_SUM;
         end
         F_SUM: begin
            pos_in = {2'd0, shape_position, 10'd0} + {4'd0, jl_ff} + POS_WRAP
                     - {5'd0, jitter_amount, 7'd0};
            state_in = F_WRAP1;
         end
         F_WRAP1, F_WRAP2: begin
            if (pos_ff >= POS_WRAP) begin
               pos_in = pos_ff - POS_WRAP;
            end
            state_in = (state_ff == F_WRAP1) ? F_WRAP2 : F_SQ;
         end
         F_SQ: begin
            x2_in    = sq_prod[31:16];
            state_in = F_MORPH;
         end
         F_MORPH: begin
            m_in     = (morph_prod[33:16] > 18'h0FFFF) ? 16'hFFFF : morph_prod[31:16];
            state_in = F_SEG;
         end
         F_SEG: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         jl_ff    <= '0;
      end else begin
         state_ff <= state_in;
         jl_ff    <= jl_in;
      end
      phase_ff <= phase_in;
      noise_ff <= noise_in;
      r_ff     <= r_in;
      pos_ff   <= pos_in;
      x2_ff    <= x2_in;
      m_ff     <= m_in;
      if (state_ff == F_SEG) begin
         seg_ff <= seg_in;
      end
   end

   assign req_ready = (state_ff == F_IDLE);
   assign push_data = seg_ff;

endmodule

// File: rtl/mwg_queue.sv
// Short queue of classified words between front and back end.
// Depends on mwg_pkg.
module mwg_queue
   import mwg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  seg_type push_data,
   input  logic    pop,
   output seg_type pop_data,
   output logic    full,
   output logic    empty
);

   seg_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == QCNT_W'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/mwg_back.sv
// Back end: bit-serial segment ramp division, loudness scaling, saturation
// and the output register. Depends on mwg_pkg.
module mwg_back
   import mwg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        empty,
   input  seg_type     pop_data,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_sample
);

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_DIV  = 4'b0010,
      B_MUL  = 4'b0100,
      B_OUT  = 4'b1000
   } bstate_type;

   bstate_type  state_ff, state_in;
   seg_type     seg_ff, seg_in;
   logic [17:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        valid_ff, valid_in;
   logic [15:0] sample_ff, sample_in;

   logic [17:0]        rem_sh;
   logic               fits;
   logic signed [16:0] v;
   logic [16:0]        absv;
   logic [33:0]        prod;

   assign rem_sh = {rem_ff[16:0], 1'b0};
   assign fits   = (rem_sh >= {1'b0, seg_ff.den});
   assign v      = seg_ff.sub
                   ? seg_ff.base - $signed({1'b0, seg_ff.use_ramp ? quo_ff : 16'd0})
                   : seg_ff.base + $signed({1'b0, seg_ff.use_ramp ? quo_ff : 16'd0});
   assign absv   = v[16] ? 17'(-v) : 17'(v);
   assign prod   = absv * seg_ff.amp;

   always_comb begin
      state_in  = state_ff;
      seg_in    = seg_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      valid_in  = valid_ff && !rsp_ready;
      sample_in = sample_ff;
      pop       = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               seg_in   = pop_data;
               rem_in   = {2'd0, pop_data.num};
               quo_in   = '0;
               cnt_in   = pop_data.sh16 ? 5'd16 : 5'd15;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            // one quotient bit per cycle; the remainder stays below den
            rem_in   = fits ? rem_sh - {1'b0, seg_ff.den} : rem_sh;
            quo_in   = {quo_ff[14:0], fits};
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == 5'd1) begin
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            mag_in   = prod[32:16];
            neg_in   = v[16];
            state_in = B_OUT;
         end
         B_OUT: begin
            if (!valid_ff || rsp_ready) begin
               valid_in = 1'b1;
               if (neg_ff) begin
                  sample_in = 16'(-mag_ff);
               end else begin
                  sample_in = (mag_ff > 17'd32767) ? 16'h7FFF : mag_ff[15:0];
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      seg_ff    <= seg_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      sample_ff <= sample_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_sample = sample_ff;

endmodule

// File: rtl/morphing_waveshape_generator_unit.sv
// Top level of the morphing waveshape generator: register port, front end,
// queue and back end. Depends on mwg_pkg, mwg_front, mwg_queue, mwg_back.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_phase Q0.16, req_noise Q0.16
//   rsp      out        rsp_valid / rsp_ready  rsp_sample signed Q1.15
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// The front end takes one word at a time through multiplies, position wrap, classify.
// The back end works on one word at a time; its bit-serial divider forms 15 or 16
// quotient bits per word.
// Reset clears control state and the jitter level; csr registers reset to zero.
// A stalled rsp holds the back end; the queue then lets the front end run ahead.
module morphing_waveshape_generator_unit
   import mwg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_phase,
   input  logic [15:0] req_noise,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [15:0] rsp_sample,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] shape_ff, shape_in;
   logic [15:0] jitter_ff, jitter_in;
   logic        push, pop, q_full, q_empty;
   seg_type     push_data, pop_data;
   logic [15:0] sample_bits;

   // registers are always writable
   assign csr_ready = 1'b1;

   always_comb begin
      shape_in  = shape_ff;
      jitter_in = jitter_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SHAPE:  shape_in  = csr_data;
            CSR_JITTER: jitter_in = csr_data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff  <= '0;
         jitter_ff <= '0;
      end else begin
         shape_ff  <= shape_in;
         jitter_ff <= jitter_in;
      end
   end

   // classify: jitter, position wrap, morph, segment select
   mwg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_phase      (req_phase),
      .req_noise      (req_noise),
      .shape_position (shape_ff),
      .jitter_amount  (jitter_ff),
      .q_full         (q_full),
      .push           (push),
      .push_data      (push_data)
   );

   // decouple the two halves
   mwg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // execute: ramp division, loudness, saturation, output register
   mwg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (sample_bits)
   );

   assign rsp_sample = $signed(sample_bits);

endmodule

// File: rtl/mwg_checker.sv
// Port-level checker for the morphing waveshape generator and its bind.
// Depends on morphing_waveshape_generator_unit.
module mwg_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_sample,
   input logic        csr_ready
);

   // no word comes out right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // the front end does not accept back-to-back words
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req accepted on back-to-back cycles");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample)))
      else $error("stalled rsp word changed");

   // register port never back-pressures
   a_csr_open: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr_ready low");

endmodule

bind morphing_waveshape_generator_unit mwg_port_checker u_mwg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sample (rsp_sample),
   .csr_ready  (csr_ready)
);

// File: tb/mwg_checker.sv
// Checker for the morphing waveshape generator: watches the req, rsp and csr
// channels, predicts each sample and compares. Depends on mwg_pkg.
`timescale 1ns / 1ps
module mwg_checker
   import mwg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_phase,
   input  logic [15:0] req_noise,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic signed [15:0] rsp_sample,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);

   logic [15:0] shape_q, jitter_q;
   logic [23:0] jit_level;
   logic signed [15:0] sample_fifo[$];

   assign pending = sample_fifo.size();

   function automatic longint ramp_div(longint num, longint den, int sh);
      if (den == 0) return 0;
      return (num << sh) / den;
   endfunction

   // predict one sample and advance the jitter state
   function automatic logic signed [15:0] predict_sample(logic [15:0] ph,
                                                         logic [15:0] nz);
      longint r, pos, region, x, x2, m, amp, v, q, h, p, mag, s;
      longint e1, e2, e3, e4;
      p = ph;
      r = (longint'(nz) * jitter_q) >> 16;
      jit_level = ((127 * longint'(jit_level) + (r << 8)) >> 7) & 24'hFFFFFF;
      pos = (longint'(shape_q) << 10) + jit_level + 50331648 - (longint'(jitter_q) << 7);
      pos = pos % 50331648;
      region = pos >> 24;
      x = (pos & 24'hFFFFFF) >> 8;
      x2 = (x * x) >> 16;
      m = (x2 * (3 * 65536 - 2 * x)) >> 16;
      if (m > 65535) m = 65535;
      q = m >> 2;
      h = m >> 1;
      if (region == 0) begin
         amp = 26214 + ((39322 * m) >> 16);
         e1 = q; e2 = 65536 - q;
         if (p < e1) v = ramp_div(p, e1, 15);
         else if (p < e2) v = 32768 - ramp_div(p - e1, e2 - e1, 16);
         else v = -32768 + ramp_div(p - e2, 65536 - e2, 15);
      end else if (region == 1) begin
         amp = 65536 - ((45875 * m) >> 16);
         e1 = 16384 - q; e2 = 16384 + q; e3 = 49152 - q; e4 = 49152 + q;
         if (p < e1) v = ramp_div(p, e1, 15);
         else if (p < e2) v = 32768;
         else if (p < e3) v = 32768 - ramp_div(p - e2, e3 - e2, 16);
         else if (p < e4) v = -32768;
         else v = -32768 + ramp_div(p - e4, 65536 - e4, 15);
      end else begin
         amp = 19661 + ((6554 * m) >> 16);
         e1 = 32768 - h; e2 = 32768 + h;
         if (p < e1) v = 32768;
         else if (p < e2) v = 32768 - ramp_div(p - e1, e2 - e1, 16);
         else v = -32768;
      end
      mag = ((v < 0 ? -v : v) * amp) >> 16;
      s = v < 0 ? -mag : mag;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return s[15:0];
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shape_q <= '0;
         jitter_q <= '0;
         jit_level = '0;
         fail_count = 0;
         sample_fifo.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SHAPE) shape_q <= csr_data;
            else if (csr_index == CSR_JITTER) jitter_q <= csr_data;
         end
         if (req_valid && req_ready)
            sample_fifo.push_back(predict_sample(req_phase, req_noise));
         if (rsp_valid && rsp_ready) begin
            if (sample_fifo.size() == 0)
               report_mismatch("sample word with nothing expected");
            else if (rsp_sample !== sample_fifo[0]) begin
               report_mismatch($sformatf("sample got %0d want %0d",
                                         rsp_sample, sample_fifo[0]));
               void'(sample_fifo.pop_front());
            end else
               void'(sample_fifo.pop_front());
         end
      end
   end

endmodule

// File: tb/tb.sv
// Testbench top for morphing_waveshape_generator_unit: drives req, csr and
// rsp_ready, gives the verdict. Depends on mwg_pkg, mwg_checker and morphing_waveshape_generator_unit.
`timescale 1ns / 1ps
module tb;
   import mwg_pkg::*;

   localparam int STALL_LIMIT = 20000;

   // phase extremes and segment edges
   localparam logic [15:0] CORNERS [9] = '{16'h0000, 16'h0001, 16'h3FFF, 16'h4000,
                                           16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000,
                                           16'hFFFF};

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_valid = 0;
   logic [15:0] req_phase = 0, req_noise = 0, csr_data = 0;
   logic [1:0] csr_index = CSR_SHAPE;
   logic req_ready, rsp_valid, csr_ready;
   logic signed [15:0] rsp_sample;
   int fail_count, pending;
   int idle_pct = 36;      // chance of an idle cycle, both sides
   bit hold_rsp = 0;       // long receiver hold-off
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   morphing_waveshape_generator_unit u_top (.*);

   mwg_checker u_chk (.*);

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= !hold_rsp && ($urandom_range(99) >= idle_pct);
   end

   // watchdog: count cycles with no accepted word on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   // offer one word, with an optional random gap first; hold until taken
   task automatic send_word(logic [15:0] ph, logic [15:0] nz);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_phase <= ph; req_noise <= nz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // one phase: set the registers, then random words with phase corners, edge or random phases
   task automatic run_phase(logic [15:0] shp, logic [15:0] jit, int count);
      logic [15:0] ph, nz;
      write_reg(CSR_SHAPE, shp);
      write_reg(CSR_JITTER, jit);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: ph = {$urandom_range(3) == 0 ? 16'h0000 : 16'hFFFF};
            1: ph = 16'h4000 + 16'($urandom_range(64)) - 16'd32;
            default: ph = 16'($urandom_range(16'hFFFF));
         endcase
         nz = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
         send_word(ph, nz);
      end
      drain();
   endtask

   initial begin
      int i;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset settings, phase extremes and segment edges
      foreach (CORNERS[k]) send_word(CORNERS[k], 16'h0000);
      send_word(16'h0000, 16'h0000);
      send_word(16'h8000, 16'hFFFF);
      send_word(16'hFFFF, 16'h1234);
      drain();
      // region boundaries and out-of-range shape position
      run_phase(16'd16384, 16'h0000, 6);
      run_phase(16'd32768, 16'h0000, 6);
      run_phase(16'd49151, 16'h0000, 6);
      run_phase(16'hFFFF, 16'hFFFF, 6);
      // long hold-off: receiver stalls while sender keeps offering
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         for (i = 0; i < 8; i++) send_word(16'($urandom), 16'($urandom));
      join
      drain();
      // no idling for one stretch
      idle_pct = 0;
      run_phase(16'($urandom_range(49151)), 16'($urandom), 60);
      idle_pct = 36;
      for (int ph = 0; ph < 6; ph++)
         run_phase($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(49151)),
                   $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4095)), 65);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: morphing_waveshape_generator_unit.f
rtl/mwg_pkg.sv
rtl/mwg_front.sv
rtl/mwg_queue.sv
rtl/mwg_back.sv
rtl/morphing_waveshape_generator_unit.sv
rtl/mwg_checker.sv
tb/mwg_checker.sv
tb/tb.sv
